[rtl/dbc7_pkg.sv]
// shared constants, types and segment decode for the debounced button counter
package dbc7_pkg;

   localparam int unsigned LEVEL_BITS = 8;
   localparam int unsigned HIST_BITS  = 16;
   localparam int unsigned COUNT_BITS = 10;
   localparam int unsigned SEG_BITS   = 8;

   localparam logic [HIST_BITS-1:0]  HISTORY_FORCE = 16'hE000;
   localparam logic [HIST_BITS-1:0]  HISTORY_PRESS = 16'hF000;
   localparam logic [COUNT_BITS:0]   COUNT_LIMIT   = 11'd1023;
   localparam logic [SEG_BITS-1:0]   SEG_BLANK     = 8'hFF;

   // active-low digit codes, bit0 is segment a
   localparam logic [SEG_BITS-1:0] SEG_DIGIT_0 = 8'b11000000;
   localparam logic [SEG_BITS-1:0] SEG_DIGIT_1 = 8'b11111001;
   localparam logic [SEG_BITS-1:0] SEG_DIGIT_2 = 8'b10100100;
   localparam logic [SEG_BITS-1:0] SEG_DIGIT_3 = 8'b10110000;
   localparam logic [SEG_BITS-1:0] SEG_DIGIT_4 = 8'b10011001;
   localparam logic [SEG_BITS-1:0] SEG_DIGIT_5 = 8'b10010010;
   localparam logic [SEG_BITS-1:0] SEG_DIGIT_6 = 8'b10000010;
   localparam logic [SEG_BITS-1:0] SEG_DIGIT_7 = 8'b11111000;
   localparam logic [SEG_BITS-1:0] SEG_DIGIT_8 = 8'b10000000;
   localparam logic [SEG_BITS-1:0] SEG_DIGIT_9 = 8'b10010000;

   // the four digit codes of one readout
   typedef struct packed {
      logic [SEG_BITS-1:0] ones;
      logic [SEG_BITS-1:0] tens;
      logic [SEG_BITS-1:0] hundreds;
      logic [SEG_BITS-1:0] thousands;
   } seg_group_type;

   // one decimal digit to its segment code
   function automatic logic [SEG_BITS-1:0] seg_of(input logic [3:0] digit);
      logic [SEG_BITS-1:0] code;
      unique case (digit)
         4'd0:    code = SEG_DIGIT_0;
         4'd1:    code = SEG_DIGIT_1;
         4'd2:    code = SEG_DIGIT_2;
         4'd3:    code = SEG_DIGIT_3;
         4'd4:    code = SEG_DIGIT_4;
         4'd5:    code = SEG_DIGIT_5;
         4'd6:    code = SEG_DIGIT_6;
         4'd7:    code = SEG_DIGIT_7;
         4'd8:    code = SEG_DIGIT_8;
         4'd9:    code = SEG_DIGIT_9;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

endpackage

[rtl/dbc7_debounce.sv]
// per-button shift-register debounce with one press pulse per held press
module dbc7_debounce #(
   parameter int unsigned BUTTONS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [dbc7_pkg::LEVEL_BITS-1:0]     levels,
   output logic [BUTTONS-1:0]                  press
);
   import dbc7_pkg::*;

   logic [HIST_BITS-1:0] history_ff [BUTTONS];
   logic [HIST_BITS-1:0] history_in [BUTTONS];

   for (genvar i = 0; i < BUTTONS; i++) begin : g_button
      logic level;

      // buttons with no input pin read as released
      if (i < LEVEL_BITS) begin : g_pin
         assign level = levels[i];
      end else begin : g_nopin
         assign level = 1'b1;
      end

      // shifted history and press detect
      assign history_in[i] = {history_ff[i][HIST_BITS-2:0], level} | HISTORY_FORCE;
      assign press[i]      = (history_in[i] == HISTORY_PRESS);
   end

   // history registers, all buttons move together on a beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTONS; i++) begin
            history_ff[i] <= '0;
         end
      end else if (advance) begin
         for (int i = 0; i < BUTTONS; i++) begin
            history_ff[i] <= history_in[i];
         end
      end
   end

endmodule

[rtl/dbc7_display.sv]
// binary count to four blanked seven-segment digit codes
module dbc7_display (
   input  logic [dbc7_pkg::COUNT_BITS-1:0] count,
   output dbc7_pkg::seg_group_type         segs
);
   import dbc7_pkg::*;

   logic [17:0] prod10;
   logic [15:0] prod100;
   logic [6:0]  q10;
   logic [3:0]  q100;
   logic [3:0]  ones_digit;
   logic [3:0]  tens_digit;
   logic [3:0]  hund_digit;
   logic [3:0]  thou_digit;
   logic [9:0]  q10_x10;
   logic [6:0]  q100_x10;

   // reciprocal divides, exact for counts below 1024
   always_comb begin
      prod10     = 18'(count) * 18'd205;
      prod100    = 16'(count) * 16'd41;
      q10        = prod10[17:11];
      q100       = prod100[15:12];
      q10_x10    = 10'({3'b000, q10} * 10'd10);
      q100_x10   = 7'({3'b000, q100} * 7'd10);
      ones_digit = 4'(count - q10_x10);
      tens_digit = 4'(q10 - q100_x10);
      hund_digit = (q100 >= 4'd10) ? 4'(q100 - 4'd10) : q100;
      thou_digit = (count >= 10'd1000) ? 4'd1 : 4'd0;
   end

   // leading-zero blanking
   always_comb begin
      segs.ones      = seg_of(ones_digit);
      segs.tens      = (count < 10'd10)   ? SEG_BLANK : seg_of(tens_digit);
      segs.hundreds  = (count < 10'd100)  ? SEG_BLANK : seg_of(hund_digit);
      segs.thousands = (count < 10'd1000) ? SEG_BLANK : seg_of(thou_digit);
   end

endmodule

[rtl/debounced_button_counter_7seg.sv]
// top level: debounced button counter with seven-segment readout
//
//   channel | direction | payload                                  | handshake
//   req     | in        | button_levels                            | req_valid / req_ready
//   rsp     | out       | count_value, ones/tens/hundreds/thousands | rsp_valid / rsp_ready
//
// one scan tick per cycle while the result register is not stalled; a tick sits in the input
// register and then waits in the result register
// the count add, wrap and digit decode sit between the two registers
// reset clears both valid flags, the button histories and the count
// a stalled result holds the input register; req_ready is high while the input register is empty or out_free
module debounced_button_counter_7seg #(
   parameter int unsigned BUTTONS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dbc7_pkg::LEVEL_BITS-1:0]     req_button_levels,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dbc7_pkg::COUNT_BITS-1:0]     rsp_count_value,
   output logic [dbc7_pkg::SEG_BITS-1:0]       rsp_ones_segments,
   output logic [dbc7_pkg::SEG_BITS-1:0]       rsp_tens_segments,
   output logic [dbc7_pkg::SEG_BITS-1:0]       rsp_hundreds_segments,
   output logic [dbc7_pkg::SEG_BITS-1:0]       rsp_thousands_segments
);
   import dbc7_pkg::*;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [LEVEL_BITS-1:0]  levels_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;
   seg_group_type          segs_ff;
   seg_group_type          segs_in;
   logic [BUTTONS-1:0]     press;
   logic [COUNT_BITS:0]    sum;
   logic                   advance;
   logic                   out_free;

   // pipeline control
   assign out_free    = !out_valid_ff || rsp_ready;
   assign advance     = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || out_free;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         levels_ff <= req_button_levels;
      end
   end

   dbc7_debounce #(
      .BUTTONS (BUTTONS)
   ) u_debounce (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .levels  (levels_ff),
      .press   (press)
   );

   // press weights and wrap
   always_comb begin
      sum      = {1'b0, count_ff} + (COUNT_BITS+1)'(press);
      count_in = (sum > COUNT_LIMIT) ? '0 : sum[COUNT_BITS-1:0];
   end

   dbc7_display u_display (
      .count (count_in),
      .segs  (segs_in)
   );

   // running count and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         segs_ff <= segs_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_count_value        = count_ff;
   assign rsp_ones_segments      = segs_ff.ones;
   assign rsp_tens_segments      = segs_ff.tens;
   assign rsp_hundreds_segments  = segs_ff.hundreds;
   assign rsp_thousands_segments = segs_ff.thousands;

`ifndef ASSERT_OFF
   // the count moves only when a beat passes into the result register
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff))
      else $error("count changed without a beat");

   // a shown result never blanks the ones digit
   a_ones_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ones_segments != SEG_BLANK)
      else $error("ones digit blanked");

   // small counts blank the tens digit
   a_tens_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count_value < 10'd10 |-> rsp_tens_segments == SEG_BLANK)
      else $error("tens digit not blanked");

   // a waiting tick is not lost while the result stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(levels_ff))
      else $error("stalled tick dropped");
`endif

endmodule
